FILE: hw/rtl/fbde_pkg.sv
`default_nettype none

package fbde_pkg;

	localparam int BUTTON_COUNT = 5;
	localparam int COUNT_WIDTH = 16;
	localparam int PERIOD_WIDTH = 16;
	localparam int CMP_WIDTH = (COUNT_WIDTH > PERIOD_WIDTH) ? COUNT_WIDTH : PERIOD_WIDTH;
	localparam int CODE_WIDTH = $clog2(BUTTON_COUNT + 2);

	localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(30);

	localparam logic [CODE_WIDTH-1:0] EV_NONE = '0;
	localparam logic [CODE_WIDTH-1:0] EV_CONFLICT = CODE_WIDTH'(BUTTON_COUNT + 1);

	typedef logic [BUTTON_COUNT-1:0] btn_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [PERIOD_WIDTH-1:0] period_t;
	typedef logic [CODE_WIDTH-1:0] code_t;

	// none, lowest set button (bit k reports k+1), or conflict
	function automatic code_t event_for(btn_t snap);
		code_t first;
		int n;
		first = EV_NONE;
		n = 0;
		for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
			if (snap[i]) begin
				first = CODE_WIDTH'(i + 1);
				n = n + 1;
			end
		end
		if (n == 0) begin
			return EV_NONE;
		end else if (n > 1) begin
			return EV_CONFLICT;
		end
		return first;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/five_button_debounce_event.sv
`default_nettype none

// Restart-timer debounce for five active-low buttons with a one-shot event read.
// Each input transaction is one tick: button levels, falling-edge flags and a
// read strobe. An edge marks its button pending and restarts the window; once
// debounce_period edge-free ticks have passed, pending buttons still held low
// become confirmed. A tick with read_event set yields one output transaction:
// none, the single confirmed button, or conflict, taken from the confirmed set
// as it stood before that tick, and clears that set. Ticks are accepted one per
// cycle while the input is not stalled; each tick is held in the input register
// and a read tick's event is then registered in the output register. Input
// stalls only when a read tick sits in the input register while an undelivered
// event blocks the output register. Write debounce_period only while idle.
module five_button_debounce_event (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire fbde_pkg::period_t             cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire fbde_pkg::btn_t                pin_levels,
	input  wire fbde_pkg::btn_t                falling_edges,
	input  wire logic                          read_event,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output fbde_pkg::code_t                    event_code
);

	fbde_pkg::period_t period_q;
	fbde_pkg::btn_t    pending_q;
	fbde_pkg::btn_t    confirmed_q;
	fbde_pkg::count_t  count_q;
	logic              running_q;

	logic              valid_s1;
	fbde_pkg::btn_t    pins_s1;
	fbde_pkg::btn_t    edges_s1;
	logic              rd_s1;

	logic              adv_s1;
	fbde_pkg::btn_t    pending_d;
	fbde_pkg::btn_t    confirmed_d;
	fbde_pkg::count_t  count_d;
	logic              running_d;
	fbde_pkg::count_t  count_inc;

	// hold a read tick while the previous event is still waiting
	assign adv_s1 = valid_s1 && !(rd_s1 && out_valid && out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_comb begin
		pending_d = pending_q;
		confirmed_d = rd_s1 ? '0 : confirmed_q;
		count_d = count_q;
		running_d = running_q;
		count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
		if (edges_s1 != '0) begin
			pending_d = pending_q | edges_s1;
			count_d = '0;
			running_d = 1'b1;
		end else if (running_q) begin
			count_d = count_inc;
			if (fbde_pkg::CMP_WIDTH'(count_inc) >= fbde_pkg::CMP_WIDTH'(period_q)) begin
				confirmed_d = confirmed_d | (pending_q & ~pins_s1);
				pending_d = '0;
				running_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= fbde_pkg::PERIOD_RESET;
		end else if (cfg_wr_en) begin
			period_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pins_s1 <= pin_levels;
			edges_s1 <= falling_edges;
			rd_s1 <= read_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			confirmed_q <= '0;
			count_q <= '0;
			running_q <= 1'b0;
		end else if (adv_s1) begin
			pending_q <= pending_d;
			confirmed_q <= confirmed_d;
			count_q <= count_d;
			running_q <= running_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1 && rd_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && rd_s1) begin
			event_code <= fbde_pkg::event_for(confirmed_q);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/fbde_checker.sv
`default_nettype none

module fbde_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire fbde_pkg::btn_t    pin_levels,
	input wire fbde_pkg::btn_t    falling_edges,
	input wire logic              read_event,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire fbde_pkg::code_t   event_code
);

	// a waiting event stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code))
		else $error("event changed or dropped while stalled");

	// a stalled tick keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid
			&& $stable({pin_levels, falling_edges, read_event}))
		else $error("input transaction changed while stalled");

	// input backpressure comes only from a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= fbde_pkg::EV_CONFLICT)
		else $error("event code out of range");

	a_reset_quiet: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid && !in_stall)
		else $error("activity right after reset");

endmodule

bind five_button_debounce_event fbde_checker u_fbde_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.pin_levels(pin_levels),
	.falling_edges(falling_edges),
	.read_event(read_event),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.event_code(event_code)
);

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam fbde_pkg::btn_t BTN_NONE  = '0;
	localparam fbde_pkg::btn_t BTN_ALL   = '1;
	localparam fbde_pkg::btn_t BTN_UP    = 5'b00001;
	localparam fbde_pkg::btn_t BTN_DOWN  = 5'b00010;
	localparam fbde_pkg::btn_t BTN_LEFT  = 5'b00100;
	localparam fbde_pkg::btn_t BTN_RIGHT = 5'b01000;
	localparam fbde_pkg::btn_t BTN_PUSH  = 5'b10000;

	localparam fbde_pkg::code_t EV_NONE     = fbde_pkg::EV_NONE;
	localparam fbde_pkg::code_t EV_CONFLICT = fbde_pkg::EV_CONFLICT;
	localparam fbde_pkg::code_t EV_UP    = fbde_pkg::code_t'(1);
	localparam fbde_pkg::code_t EV_DOWN  = fbde_pkg::code_t'(2);
	localparam fbde_pkg::code_t EV_LEFT  = fbde_pkg::code_t'(3);
	localparam fbde_pkg::code_t EV_RIGHT = fbde_pkg::code_t'(4);
	localparam fbde_pkg::code_t EV_PUSH  = fbde_pkg::code_t'(5);

	localparam int MAX_GAP = 11;

	typedef struct {
		fbde_pkg::btn_t  pins;
		fbde_pkg::btn_t  edges;
		logic            rd;
		int unsigned     reps;
		logic            typed;
		fbde_pkg::code_t code;
	} tick_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	fbde_pkg::period_t cfg_wr_data;
	logic              in_valid;
	logic              in_stall;
	fbde_pkg::btn_t    pin_levels;
	fbde_pkg::btn_t    falling_edges;
	logic              read_event;
	logic              out_valid;
	logic              out_stall;
	fbde_pkg::code_t   event_code;

	five_button_debounce_event i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pin_levels    (pin_levels),
		.falling_edges (falling_edges),
		.read_event    (read_event),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_code    (event_code)
	);

	// shadow copy of the debounce state
	fbde_pkg::period_t shadow_period    = fbde_pkg::PERIOD_RESET;
	fbde_pkg::btn_t    shadow_pending   = '0;
	fbde_pkg::btn_t    shadow_confirmed = '0;
	fbde_pkg::count_t  shadow_count     = '0;
	logic              shadow_running   = 1'b0;

	fbde_pkg::code_t expected_events[$];
	int              mismatch_count = 0;

	// fixed expectation that overrides the shadow for the tick being driven
	logic            typed_check = 1'b0;
	fbde_pkg::code_t typed_code  = EV_NONE;

	logic tx_idle = 1'b1;
	logic rx_idle = 1'b1;

	fbde_pkg::btn_t gen_pins = '1;
	int             gen_hold = 0;

	tick_row_t dir_rows[$];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic fbde_pkg::code_t decode_event(fbde_pkg::btn_t snap);
		fbde_pkg::code_t code;
		code = EV_NONE;
		if ($countones(snap) > 1) begin
			return EV_CONFLICT;
		end
		for (int b = 0; b < fbde_pkg::BUTTON_COUNT; b++) begin
			if (snap[b]) begin
				code = fbde_pkg::code_t'(b + 1);
			end
		end
		return code;
	endfunction

	// shadow update and output check
	always @(posedge clk) begin
		fbde_pkg::code_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("unexpected event transaction: code %0d", event_code);
					end
					mismatch_count++;
				end else begin
					want = expected_events.pop_front();
					if (event_code !== want) begin
						if (mismatch_count < 10) begin
							$display("event_code mismatch: expected %0d, got %0d",
								want, event_code);
						end
						mismatch_count++;
					end
				end
			end
			if (cfg_wr_en) begin
				shadow_period = cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				// read sees the confirmed set from before this tick
				if (read_event) begin
					want = typed_check ? typed_code : decode_event(shadow_confirmed);
					expected_events.push_back(want);
					shadow_confirmed = '0;
				end
				if (falling_edges != '0) begin
					shadow_pending = shadow_pending | falling_edges;
					shadow_count = '0;
					shadow_running = 1'b1;
				end else if (shadow_running) begin
					if (shadow_count != '1) begin
						shadow_count = shadow_count + 1'b1;
					end
					if (shadow_count >= shadow_period) begin
						shadow_confirmed = shadow_confirmed | (shadow_pending & ~pin_levels);
						shadow_pending = '0;
						shadow_running = 1'b0;
					end
				end
			end
		end
	end

	// event sink: draw a stall length, then hold ready until one transaction
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			n = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			for (int k = 0; k < n; k++) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
		end
	end

	task automatic send_tick(input fbde_pkg::btn_t pins, input fbde_pkg::btn_t edges,
			input logic rd, input logic typed, input fbde_pkg::code_t code);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		for (int k = 0; k < gap; k++) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		pin_levels <= pins;
		falling_edges <= edges;
		read_event <= rd;
		typed_check = typed;
		typed_code = code;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic drain_events();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
	endtask

	task automatic write_period(input fbde_pkg::period_t value);
		drain_events();
		// let ticks without a read leave the pipeline
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// bounce bursts with holds around the window length, plus some noise
	task automatic run_random(input int count);
		fbde_pkg::btn_t pins;
		fbde_pkg::btn_t edges;
		fbde_pkg::btn_t flip;
		logic           rd;
		int             span;
		for (int i = 0; i < count; i++) begin
			span = (shadow_period > 40) ? 40 : int'(shadow_period);
			if ($urandom_range(0, 99) < 8) begin
				pins = fbde_pkg::btn_t'($urandom);
				edges = fbde_pkg::btn_t'($urandom);
			end else if (gen_hold > 0) begin
				pins = gen_pins;
				edges = BTN_NONE;
				gen_hold--;
			end else begin
				flip = fbde_pkg::btn_t'($urandom) & fbde_pkg::btn_t'($urandom);
				if (flip == BTN_NONE) begin
					flip = BTN_UP << $urandom_range(0, fbde_pkg::BUTTON_COUNT - 1);
				end
				pins = gen_pins ^ flip;
				edges = gen_pins & ~pins;
				gen_hold = $urandom_range(0, 2 * span + 1);
			end
			gen_pins = pins;
			rd = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 59) == 0) begin
				drain_events();
			end
			send_tick(pins, edges, rd, 1'b0, EV_NONE);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		pin_levels = '1;
		falling_edges = '0;
		read_event = 1'b0;

		// directed ticks, all at the reset period of 30
		dir_rows.push_back('{BTN_ALL, BTN_NONE, 1'b1, 1, 1'b1, EV_NONE});
		dir_rows.push_back('{~BTN_UP, BTN_UP, 1'b0, 1, 1'b0, EV_NONE});
		dir_rows.push_back('{~BTN_UP, BTN_NONE, 1'b0, 29, 1'b0, EV_NONE});
		// read on the tick that confirms: still sees the old set
		dir_rows.push_back('{~BTN_UP, BTN_NONE, 1'b1, 1, 1'b1, EV_NONE});
		dir_rows.push_back('{BTN_ALL, BTN_NONE, 1'b1, 1, 1'b1, EV_UP});
		dir_rows.push_back('{BTN_ALL, BTN_NONE, 1'b1, 1, 1'b1, EV_NONE});
		dir_rows.push_back('{BTN_NONE, BTN_ALL, 1'b0, 1, 1'b0, EV_NONE});
		dir_rows.push_back('{BTN_NONE, BTN_NONE, 1'b0, 29, 1'b0, EV_NONE});
		// edge on the tick that would time out restarts the window
		dir_rows.push_back('{BTN_NONE, BTN_PUSH, 1'b0, 1, 1'b0, EV_NONE});
		dir_rows.push_back('{BTN_NONE, BTN_NONE, 1'b1, 29, 1'b1, EV_NONE});
		dir_rows.push_back('{BTN_NONE, BTN_NONE, 1'b1, 1, 1'b1, EV_NONE});
		dir_rows.push_back('{BTN_ALL, BTN_NONE, 1'b1, 1, 1'b1, EV_CONFLICT});
		// released before the window ends: nothing confirmed
		dir_rows.push_back('{~BTN_DOWN, BTN_DOWN, 1'b0, 1, 1'b0, EV_NONE});
		dir_rows.push_back('{BTN_ALL, BTN_NONE, 1'b0, 30, 1'b0, EV_NONE});
		dir_rows.push_back('{BTN_ALL, BTN_NONE, 1'b1, 1, 1'b1, EV_NONE});
		dir_rows.push_back('{~BTN_RIGHT, BTN_RIGHT | BTN_LEFT, 1'b1, 1, 1'b1, EV_NONE});
		dir_rows.push_back('{~BTN_RIGHT, BTN_NONE, 1'b0, 30, 1'b0, EV_NONE});
		dir_rows.push_back('{~BTN_RIGHT, BTN_NONE, 1'b1, 1, 1'b1, EV_RIGHT});
		dir_rows.push_back('{~BTN_LEFT, BTN_LEFT, 1'b0, 1, 1'b0, EV_NONE});
		dir_rows.push_back('{~BTN_LEFT, BTN_NONE, 1'b0, 30, 1'b0, EV_NONE});
		dir_rows.push_back('{~BTN_PUSH, BTN_PUSH, 1'b1, 1, 1'b1, EV_LEFT});
		dir_rows.push_back('{~BTN_PUSH, BTN_NONE, 1'b0, 30, 1'b0, EV_NONE});
		dir_rows.push_back('{BTN_ALL, BTN_NONE, 1'b1, 1, 1'b1, EV_PUSH});
		dir_rows.push_back('{~BTN_DOWN, BTN_DOWN, 1'b0, 1, 1'b0, EV_NONE});
		dir_rows.push_back('{~BTN_DOWN, BTN_NONE, 1'b0, 30, 1'b0, EV_NONE});
		dir_rows.push_back('{BTN_ALL, BTN_NONE, 1'b1, 1, 1'b1, EV_DOWN});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			for (int k = 0; k < dir_rows[r].reps; k++) begin
				send_tick(dir_rows[r].pins, dir_rows[r].edges, dir_rows[r].rd,
					dir_rows[r].typed, dir_rows[r].code);
			end
		end
		gen_pins = BTN_ALL;

		run_random(150);

		write_period(fbde_pkg::period_t'(1));
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		run_random(150);

		write_period(fbde_pkg::period_t'(2));
		tx_idle = 1'b1;
		run_random(120);

		write_period(fbde_pkg::period_t'(5));
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		run_random(120);

		write_period(fbde_pkg::period_t'(13));
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		run_random(120);

		write_period(fbde_pkg::period_t'(3));
		run_random(135);

		drain_events();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/fbde_pkg.sv
hw/rtl/five_button_debounce_event.sv
hw/rtl/fbde_checker.sv
dv/tb.sv
